FILE: src/stream_find_and_replace_defines.svh
// Assertion helpers for the find-and-replace block.
`ifndef STREAM_FIND_AND_REPLACE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAF_ASSERT_NOW(label, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAF_ASSERT_NEXT(label, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error(msg);

`endif

FILE: src/saf_pkg.sv
package saf_pkg;

    localparam int JOB_BYTES = 8;
    localparam int JOB_W     = JOB_BYTES * 8;
    localparam int IDX_W     = $clog2(JOB_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] NEWLINE = 8'd10;
    localparam logic [3:0] MAX_REPLACE = 4'd8;

    // configuration register indexes
    localparam logic [1:0] REG_PATTERN_LEN  = 2'd0;
    localparam logic [1:0] REG_PATTERN_WORD = 2'd1;
    localparam logic [1:0] REG_REPLACE_LEN  = 2'd2;
    localparam logic [1:0] REG_REPLACE_WORD = 2'd3;

    typedef struct packed {
        logic [3:0]  pattern_len;
        logic [63:0] pattern_word;
        logic [3:0]  replace_len;
        logic [63:0] replace_word;
    } cfg_t;

    // one unit of output work: cnt bytes from data, lowest byte first
    typedef struct packed {
        logic [JOB_W-1:0] data;
        logic [3:0]       cnt;
        logic             eol;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

FILE: src/saf_front.sv
module saf_front
    import saf_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       clear_win,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       end_of_line,
    output logic       job_valid,
    output job_t       job
);

    localparam int WIN  = (MAX_PATTERN < JOB_BYTES) ? MAX_PATTERN : JOB_BYTES;
    localparam int FW   = $clog2(WIN + 1);

    logic [WIN*8-1:0] win_reg, win_next, win_ins;
    logic [FW-1:0]    fill_reg, fill_next, fill_inc;
    logic [3:0]       len_eff, rl_eff;
    logic             match;
    logic [JOB_W-1:0] flush_data;

    always_comb
    begin
        if (cfg.pattern_len == 4'd0)
            len_eff = 4'd1;
        else if (cfg.pattern_len > 4'(WIN))
            len_eff = 4'(WIN);
        else
            len_eff = cfg.pattern_len;

        rl_eff = (cfg.replace_len > MAX_REPLACE) ? MAX_REPLACE : cfg.replace_len;
    end

    always_comb
    begin
        win_ins = win_reg;
        for (int i = 0; i < WIN; i++)
        begin
            if (i == int'(fill_reg))
                win_ins[i*8 +: 8] = in_byte;
        end
        fill_inc = fill_reg + 1'b1;

        match = 1'b1;
        for (int i = 0; i < WIN; i++)
        begin
            if ((i < int'(len_eff)) && (win_ins[i*8 +: 8] != cfg.pattern_word[i*8 +: 8]))
                match = 1'b0;
        end

        // held bytes followed by the newline
        flush_data = JOB_W'(win_reg);
        for (int i = 0; i < JOB_BYTES; i++)
        begin
            if (i == int'(fill_reg))
                flush_data[i*8 +: 8] = NEWLINE;
        end
    end

    always_comb
    begin
        job_valid = 1'b0;
        job       = '0;
        win_next  = win_reg;
        fill_next = fill_reg;
        if (clear_win)
        begin
            fill_next = '0;
        end
        else if (in_valid)
        begin
            if (end_of_line)
            begin
                job_valid = 1'b1;
                job.data  = flush_data;
                job.cnt   = 4'(fill_reg) + 4'd1;
                job.eol   = 1'b1;
                fill_next = '0;
            end
            else if (4'(fill_inc) >= len_eff)
            begin
                if (match)
                begin
                    fill_next = '0;
                    if (rl_eff != 4'd0)
                    begin
                        job_valid = 1'b1;
                        job.data  = cfg.replace_word;
                        job.cnt   = rl_eff;
                    end
                end
                else
                begin
                    // emit the oldest byte and slide
                    job_valid = 1'b1;
                    job.data  = JOB_W'(win_ins[7:0]);
                    job.cnt   = 4'd1;
                    win_next  = win_ins >> 8;
                    fill_next = fill_reg;
                end
            end
            else
            begin
                win_next  = win_ins;
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

FILE: src/saf_queue.sv
module saf_queue
    import saf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   push_job,
    input  logic   pop,
    output job_t   head,
    output qstat_t stat
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: src/saf_back.sv
module saf_back
    import saf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qstat_t     q_stat,
    input  job_t       q_head,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       line_end,
    output logic       last
);

    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             advance, finish, load;

    assign empty    = !busy_reg;
    assign last     = ({1'b0, idx_reg} == (job_reg.cnt - 4'd1));
    assign out_byte = job_reg.data[{idx_reg, 3'b000} +: 8];
    assign line_end = job_reg.eol && last;

    assign advance = busy_reg && pop;
    assign finish  = advance && last;
    assign load    = !q_stat.empty && (!busy_reg || finish);
    assign q_pop   = load;

    always_comb
    begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            job_next  = q_head;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

FILE: src/stream_find_and_replace.sv
// Channel   Handshake            Payload
// input     push / full          in_byte, end_of_line
// result    pop / empty          out_byte, line_end, last
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front takes one item per cycle while the two-entry job queue has room.
// The back sends one result per cycle while pop is held; an item with n results
// holds it for n pops (up to 8), so the rate is set by the back's byte counter.
// Reset clears window count and queue; config resets to pattern_len 1, rest 0.
// A stalled pop backs up the queue, which then raises full.
`include "stream_find_and_replace_defines.svh"

module stream_find_and_replace
    import saf_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_line,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        line_end,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t   cfg_reg, cfg_next;
    logic   cfg_wr, clear_win;
    logic   in_valid, job_valid, q_pop;
    job_t   job, q_head;
    qstat_t q_stat;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign clear_win = cfg_wr && (cfg_index == REG_PATTERN_LEN);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_PATTERN_LEN:  cfg_next.pattern_len  = cfg_data[3:0];
                REG_PATTERN_WORD: cfg_next.pattern_word = cfg_data;
                REG_REPLACE_LEN:  cfg_next.replace_len  = cfg_data[3:0];
                REG_REPLACE_WORD: cfg_next.replace_word = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_len  <= 4'd1;
            cfg_reg.pattern_word <= '0;
            cfg_reg.replace_len  <= '0;
            cfg_reg.replace_word <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full     = q_stat.full;
    assign in_valid = push && !q_stat.full;

    saf_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear_win   (clear_win),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .end_of_line (end_of_line),
        .job_valid   (job_valid),
        .job         (job)
    );

    saf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    saf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .line_end (line_end),
        .last     (last)
    );

    `SAF_ASSERT_NOW(a_line_end_last, !empty && line_end, last, "line end not on last result")
    `SAF_ASSERT_NOW(a_line_end_nl, !empty && line_end, out_byte == NEWLINE, "line end not newline")
    `SAF_ASSERT_NEXT(a_back_refill, !empty && pop && last && !q_stat.empty, !empty, "back idle with work queued")
    `SAF_ASSERT_NOW(a_no_push_full, job_valid, !q_stat.full, "job pushed into full queue")

endmodule
